// ===== hdl/lwwr_pkg.sv =====
// Shared types and constants for the longest window within range block.
`default_nettype none

package lwwr_pkg;

  // Fixed widths of the sample and the reported lengths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 11;

  // Operations of the shared compare unit.
  typedef enum logic {
    OP_LE,
    OP_RANGE
  } cmp_op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP,
    ST_FRONT,
    ST_APPEND,
    ST_PUSH_H_RD,
    ST_PUSH_H_CMP,
    ST_PUSH_H_WR,
    ST_PUSH_L_RD,
    ST_PUSH_L_CMP,
    ST_PUSH_L_WR,
    ST_CHECK,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/lwwr_cmp_unit.sv =====
// Shared compare unit: ordered compare and range check of two samples.
`default_nettype none

module lwwr_cmp_unit (
  input  var lwwr_pkg::cmp_op_e          op_i,
  input  wire [lwwr_pkg::DATA_W-1:0]     a_i,
  input  wire [lwwr_pkg::DATA_W-1:0]     b_i,
  input  wire [lwwr_pkg::DATA_W-1:0]     bound_i,
  output logic                           pass_o
);

  logic [lwwr_pkg::DATA_W:0] diff;

  // One 33-bit subtract serves both operations.
  assign diff = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    unique case (op_i)
      lwwr_pkg::OP_LE:    pass_o = diff[lwwr_pkg::DATA_W] || (diff == '0);
      lwwr_pkg::OP_RANGE: pass_o = !diff[lwwr_pkg::DATA_W] &&
                                   (diff[lwwr_pkg::DATA_W-1:0] <= bound_i);
      default:            pass_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lwwr_deque_mem.sv =====
// Candidate queue storage: one write port and one registered read port.
`default_nettype none

module lwwr_deque_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned EW    = 42
) (
  input  wire           clk_i,
  input  wire           we_i,
  input  wire  [AW-1:0] waddr_i,
  input  wire  [EW-1:0] wdata_i,
  input  wire  [AW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/longest_window_within_range.sv =====
// Top level of the longest window within range block: sequencer and state.
//
// Usage: each input transfer on sample_i appends one unsigned 32-bit sample to
// a sliding window of at most WINDOW_DEPTH samples. If the window is full the
// oldest sample is dropped first and capacity_hit_o is set. Oldest samples are
// then dropped until the window maximum minus minimum is at most the tolerance
// register. Each input transfer yields exactly one output transfer carrying
// the window length, the longest length since reset, and the window maximum
// and minimum. The tolerance register is to be written with tolerance_we_i only
// while the block is idle; the block itself does not enforce this.
// Steps: a full window first drops its oldest sample and rereads the queue
// fronts; then the sample is appended, pushed to the high and then the low queue
// after popping back candidates, and range checked, each failed check dropping
// the oldest sample and rereading the fronts; the output state follows. All
// compares go through the one compare unit. in_stall_o is high while an item
// is worked, so no new item is taken before the sequencer is through the last.
// Reset empties the window and both queues and clears the best length and the
// tolerance; the memories are not cleared and need no pass. A stalled output
// transfer holds its result; the next item is accepted meanwhile, and its
// result waits in the sequencer until the output register frees.
`default_nettype none

module longest_window_within_range #(
  parameter int unsigned WINDOW_DEPTH = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               tolerance_we_i,
  input  wire  [lwwr_pkg::DATA_W-1:0]       tolerance_i,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [lwwr_pkg::DATA_W-1:0]       sample_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [lwwr_pkg::LEN_W-1:0]        window_length_o,
  output logic [lwwr_pkg::LEN_W-1:0]        best_length_o,
  output logic [lwwr_pkg::DATA_W-1:0]       window_high_o,
  output logic [lwwr_pkg::DATA_W-1:0]       window_low_o,
  output logic                              capacity_hit_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned DW = lwwr_pkg::DATA_W;
  localparam int unsigned EW = AW + DW;
  localparam logic [AW:0]   DEPTH_C  = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

  // Ring index helpers; the sum stays below twice the depth.
  function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + b;
    if (sum >= DEPTH_C) begin
      sum = sum - DEPTH_C;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + AW'(1);
  endfunction

  lwwr_pkg::state_e state_q, state_d;

  logic [DW-1:0] tol_q;
  logic [DW-1:0] sample_q, sample_d;
  logic          hit_q, hit_d;
  logic          ret_check_q, ret_check_d;
  logic [AW-1:0] ring_head_q, ring_head_d;
  logic [AW:0]   ring_cnt_q, ring_cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] hq_head_q, hq_head_d;
  logic [AW:0]   hq_cnt_q, hq_cnt_d;
  logic [AW-1:0] lq_head_q, lq_head_d;
  logic [AW:0]   lq_cnt_q, lq_cnt_d;
  logic [AW-1:0] hf_slot_q, hf_slot_d;
  logic [DW-1:0] hf_val_q, hf_val_d;
  logic [AW-1:0] lf_slot_q, lf_slot_d;
  logic [DW-1:0] lf_val_q, lf_val_d;
  logic [AW:0]   longest_q, longest_d;

  logic                    out_valid_q;
  logic [AW:0]             out_len_q;
  logic [AW:0]             out_best_q;
  logic [DW-1:0]           out_high_q;
  logic [DW-1:0]           out_low_q;
  logic                    out_hit_q;
  logic                    load_out;

  logic          h_we, l_we;
  logic [AW-1:0] h_waddr, l_waddr, h_raddr, l_raddr;
  logic [EW-1:0] h_wdata, l_wdata, h_rdata, l_rdata;

  lwwr_pkg::cmp_op_e cmp_op;
  logic [DW-1:0]     cmp_a, cmp_b;
  logic              cmp_pass;

  // The two candidate queues hold {ring slot, sample value}, so no sample
  // store lookup is needed to compare against a candidate.
  lwwr_deque_mem #(.DEPTH(WINDOW_DEPTH), .AW(AW), .EW(EW)) u_high_mem (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  lwwr_deque_mem #(.DEPTH(WINDOW_DEPTH), .AW(AW), .EW(EW)) u_low_mem (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  lwwr_cmp_unit u_cmp (
    .op_i    (cmp_op),
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .bound_i (tol_q),
    .pass_o  (cmp_pass)
  );

  assign in_stall_o = (state_q != lwwr_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lwwr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (ring_cnt_q == DEPTH_C) ? lwwr_pkg::ST_DROP : lwwr_pkg::ST_APPEND;
        end
      end
      lwwr_pkg::ST_DROP:  state_d = lwwr_pkg::ST_FRONT;
      lwwr_pkg::ST_FRONT: state_d = ret_check_q ? lwwr_pkg::ST_CHECK : lwwr_pkg::ST_APPEND;
      lwwr_pkg::ST_APPEND: state_d = lwwr_pkg::ST_PUSH_H_RD;
      lwwr_pkg::ST_PUSH_H_RD: begin
        state_d = (hq_cnt_q == '0) ? lwwr_pkg::ST_PUSH_H_WR : lwwr_pkg::ST_PUSH_H_CMP;
      end
      lwwr_pkg::ST_PUSH_H_CMP: begin
        state_d = cmp_pass ? lwwr_pkg::ST_PUSH_H_RD : lwwr_pkg::ST_PUSH_H_WR;
      end
      lwwr_pkg::ST_PUSH_H_WR: state_d = lwwr_pkg::ST_PUSH_L_RD;
      lwwr_pkg::ST_PUSH_L_RD: begin
        state_d = (lq_cnt_q == '0) ? lwwr_pkg::ST_PUSH_L_WR : lwwr_pkg::ST_PUSH_L_CMP;
      end
      lwwr_pkg::ST_PUSH_L_CMP: begin
        state_d = cmp_pass ? lwwr_pkg::ST_PUSH_L_RD : lwwr_pkg::ST_PUSH_L_WR;
      end
      lwwr_pkg::ST_PUSH_L_WR: state_d = lwwr_pkg::ST_CHECK;
      lwwr_pkg::ST_CHECK: begin
        state_d = (cmp_pass || ring_cnt_q <= (AW + 1)'(1)) ? lwwr_pkg::ST_OUT
                                                           : lwwr_pkg::ST_DROP;
      end
      lwwr_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = lwwr_pkg::ST_IDLE;
        end
      end
      default: state_d = lwwr_pkg::ST_IDLE;
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    sample_d    = sample_q;
    hit_d       = hit_q;
    ret_check_d = ret_check_q;
    ring_head_d = ring_head_q;
    ring_cnt_d  = ring_cnt_q;
    pos_d       = pos_q;
    hq_head_d   = hq_head_q;
    hq_cnt_d    = hq_cnt_q;
    lq_head_d   = lq_head_q;
    lq_cnt_d    = lq_cnt_q;
    hf_slot_d   = hf_slot_q;
    hf_val_d    = hf_val_q;
    lf_slot_d   = lf_slot_q;
    lf_val_d    = lf_val_q;
    longest_d   = longest_q;
    load_out    = 1'b0;
    h_we        = 1'b0;
    l_we        = 1'b0;
    h_waddr     = idx_add(hq_head_q, hq_cnt_q);
    l_waddr     = idx_add(lq_head_q, lq_cnt_q);
    h_wdata     = {pos_q, sample_q};
    l_wdata     = {pos_q, sample_q};
    h_raddr     = hq_head_q;
    l_raddr     = lq_head_q;
    cmp_op      = lwwr_pkg::OP_LE;
    cmp_a       = h_rdata[DW-1:0];
    cmp_b       = sample_q;

    unique case (state_q)
      lwwr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          sample_d    = sample_i;
          hit_d       = (ring_cnt_q == DEPTH_C);
          ret_check_d = 1'b0;
        end
      end
      lwwr_pkg::ST_DROP: begin
        // Retire the oldest sample; a queue front that is this slot goes too.
        if (hq_cnt_q != '0 && hf_slot_q == ring_head_q) begin
          hq_head_d = idx_inc(hq_head_q);
          hq_cnt_d  = hq_cnt_q - (AW + 1)'(1);
        end
        if (lq_cnt_q != '0 && lf_slot_q == ring_head_q) begin
          lq_head_d = idx_inc(lq_head_q);
          lq_cnt_d  = lq_cnt_q - (AW + 1)'(1);
        end
        h_raddr     = hq_head_d;
        l_raddr     = lq_head_d;
        ring_head_d = idx_inc(ring_head_q);
        ring_cnt_d  = ring_cnt_q - (AW + 1)'(1);
      end
      lwwr_pkg::ST_FRONT: begin
        hf_slot_d = h_rdata[EW-1:DW];
        hf_val_d  = h_rdata[DW-1:0];
        lf_slot_d = l_rdata[EW-1:DW];
        lf_val_d  = l_rdata[DW-1:0];
      end
      lwwr_pkg::ST_APPEND: begin
        pos_d      = idx_add(ring_head_q, ring_cnt_q);
        ring_cnt_d = ring_cnt_q + (AW + 1)'(1);
      end
      lwwr_pkg::ST_PUSH_H_RD: begin
        h_raddr = idx_add(hq_head_q, hq_cnt_q - (AW + 1)'(1));
      end
      lwwr_pkg::ST_PUSH_H_CMP: begin
        // Drop a back candidate that is not above the new sample.
        cmp_a = h_rdata[DW-1:0];
        cmp_b = sample_q;
        if (cmp_pass) begin
          hq_cnt_d = hq_cnt_q - (AW + 1)'(1);
        end
      end
      lwwr_pkg::ST_PUSH_H_WR: begin
        h_we     = 1'b1;
        hq_cnt_d = hq_cnt_q + (AW + 1)'(1);
        if (hq_cnt_q == '0) begin
          hf_slot_d = pos_q;
          hf_val_d  = sample_q;
        end
      end
      lwwr_pkg::ST_PUSH_L_RD: begin
        l_raddr = idx_add(lq_head_q, lq_cnt_q - (AW + 1)'(1));
      end
      lwwr_pkg::ST_PUSH_L_CMP: begin
        // Drop a back candidate that is not below the new sample.
        cmp_a = sample_q;
        cmp_b = l_rdata[DW-1:0];
        if (cmp_pass) begin
          lq_cnt_d = lq_cnt_q - (AW + 1)'(1);
        end
      end
      lwwr_pkg::ST_PUSH_L_WR: begin
        l_we     = 1'b1;
        lq_cnt_d = lq_cnt_q + (AW + 1)'(1);
        if (lq_cnt_q == '0) begin
          lf_slot_d = pos_q;
          lf_val_d  = sample_q;
        end
      end
      lwwr_pkg::ST_CHECK: begin
        cmp_op = lwwr_pkg::OP_RANGE;
        cmp_a  = hf_val_q;
        cmp_b  = lf_val_q;
        if (!(cmp_pass || ring_cnt_q <= (AW + 1)'(1))) begin
          ret_check_d = 1'b1;
        end
      end
      lwwr_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          if (ring_cnt_q > longest_q) begin
            longest_d = ring_cnt_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwwr_pkg::ST_IDLE;
      tol_q       <= '0;
      ret_check_q <= 1'b0;
      ring_head_q <= '0;
      ring_cnt_q  <= '0;
      hq_head_q   <= '0;
      hq_cnt_q    <= '0;
      lq_head_q   <= '0;
      lq_cnt_q    <= '0;
      longest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (tolerance_we_i) begin
        tol_q <= tolerance_i;
      end
      ret_check_q <= ret_check_d;
      ring_head_q <= ring_head_d;
      ring_cnt_q  <= ring_cnt_d;
      hq_head_q   <= hq_head_d;
      hq_cnt_q    <= hq_cnt_d;
      lq_head_q   <= lq_head_d;
      lq_cnt_q    <= lq_cnt_d;
      longest_q   <= longest_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    hit_q     <= hit_d;
    pos_q     <= pos_d;
    hf_slot_q <= hf_slot_d;
    hf_val_q  <= hf_val_d;
    lf_slot_q <= lf_slot_d;
    lf_val_q  <= lf_val_d;
    if (load_out) begin
      out_len_q  <= ring_cnt_q;
      out_best_q <= longest_d;
      out_high_q <= hf_val_q;
      out_low_q  <= lf_val_q;
      out_hit_q  <= hit_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_length_o = lwwr_pkg::LEN_W'(out_len_q);
  assign best_length_o   = lwwr_pkg::LEN_W'(out_best_q);
  assign window_high_o   = out_high_q;
  assign window_low_o    = out_low_q;
  assign capacity_hit_o  = out_hit_q;

`ifndef SYNTHESIS
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_cnt_q <= DEPTH_C)
    else $error("window count exceeds the ring depth");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hq_cnt_q <= ring_cnt_q) && (lq_cnt_q <= ring_cnt_q))
    else $error("candidate queue holds more entries than the window");

  a_check_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lwwr_pkg::ST_CHECK) |-> (hq_cnt_q != '0) && (lq_cnt_q != '0))
    else $error("range check with an empty candidate queue");

  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lwwr_pkg::ST_IDLE) |-> (longest_q >= ring_cnt_q))
    else $error("best length below the current window length");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && (out_len_q != '0))
    else $error("result loaded without a valid nonempty window");
`endif

endmodule

`default_nettype wire
